[hw/rtl/gbte_pkg.sv]
// gbte_pkg: shared types and constants for the gap-buffer text editor.
// Holds command codes, controller states, datapath operations and the
// command/status structs between gbte_ctrl and gbte_dp. No dependencies.
`default_nettype none

package gbte_pkg;

    localparam int GBTE_CAPACITY = 4096;
    localparam int GBTE_KIND_W   = 3;
    localparam int GBTE_CHAR_W   = 8;
    localparam int GBTE_POS_W    = 13;

    typedef enum logic [GBTE_KIND_W-1:0] {
        KIND_INSERT     = 3'd0,
        KIND_BACKSPACE  = 3'd1,
        KIND_LEFT       = 3'd2,
        KIND_RIGHT      = 3'd3,
        KIND_MOVE_TO    = 3'd4,
        KIND_READ_AT    = 3'd5,
        KIND_CLEAR      = 3'd6,
        KIND_MARK_CLEAN = 3'd7
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INSERT,
        OP_BACKSPACE,
        OP_FETCH_LEFT,
        OP_FETCH_RIGHT,
        OP_STORE,
        OP_READ,
        OP_CLEAR,
        OP_CLEAN
    } dp_op_t;

    typedef struct packed {
        logic   latch;
        logic   result;
        dp_op_t op;
        logic   acc_we;
        logic   acc;
    } dp_cmd_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      full;
        logic      at_start;
        logic      at_end;
        logic      need_left;
        logic      need_right;
        logic      in_range;
    } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/gbte_ctrl.sv]
// gbte_ctrl: sequencing state machine for the gap-buffer text editor.
// Drives datapath operations and both handshakes; uses gbte_pkg.
`default_nettype none

module gbte_ctrl
    import gbte_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        take;
    logic        fetch;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) || (state_reg == ST_DONE && out_free));
    assign take      = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign fetch     = (cmd.op == OP_FETCH_LEFT) || (cmd.op == OP_FETCH_RIGHT);

    always_comb
    begin
        cmd.latch  = take;
        cmd.result = (state_reg == ST_DONE) && out_free;
        cmd.op     = OP_NONE;
        cmd.acc_we = 1'b0;
        cmd.acc    = 1'b0;
        unique case (state_reg)
            ST_EXEC:
            begin
                cmd.acc_we = 1'b1;
                unique case (stat.kind)
                    KIND_INSERT:
                    begin
                        cmd.op  = stat.full ? OP_NONE : OP_INSERT;
                        cmd.acc = !stat.full;
                    end
                    KIND_BACKSPACE:
                    begin
                        cmd.op  = stat.at_start ? OP_NONE : OP_BACKSPACE;
                        cmd.acc = !stat.at_start;
                    end
                    KIND_LEFT:
                    begin
                        cmd.op  = stat.at_start ? OP_NONE : OP_FETCH_LEFT;
                        cmd.acc = !stat.at_start;
                    end
                    KIND_RIGHT:
                    begin
                        cmd.op  = stat.at_end ? OP_NONE : OP_FETCH_RIGHT;
                        cmd.acc = !stat.at_end;
                    end
                    KIND_MOVE_TO:
                    begin
                        cmd.op  = stat.need_left  ? OP_FETCH_LEFT  :
                                  stat.need_right ? OP_FETCH_RIGHT : OP_NONE;
                        cmd.acc = 1'b1;
                    end
                    KIND_READ_AT:
                    begin
                        cmd.op  = stat.in_range ? OP_READ : OP_NONE;
                        cmd.acc = stat.in_range;
                    end
                    KIND_CLEAR:
                    begin
                        cmd.op  = OP_CLEAR;
                        cmd.acc = 1'b1;
                    end
                    KIND_MARK_CLEAN:
                    begin
                        cmd.op  = OP_CLEAN;
                        cmd.acc = 1'b1;
                    end
                    default:
                    begin
                        cmd.op  = OP_NONE;
                        cmd.acc = 1'b0;
                    end
                endcase
            end
            ST_COPY:
            begin
                cmd.op = OP_STORE;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = fetch ? ST_COPY : ST_DONE;
            end
            ST_COPY:
            begin
                state_next = (stat.kind == KIND_MOVE_TO) ? ST_EXEC : ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = take ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.result)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_copy_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COPY |->
            $past(cmd.op == OP_FETCH_LEFT || cmd.op == OP_FETCH_RIGHT))
        else $error("copy step without a preceding fetch");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    a_single_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY && stat.kind != KIND_MOVE_TO) |=> state_reg == ST_DONE)
        else $error("single cursor step did not finish after one copy");

endmodule

`default_nettype wire

[hw/rtl/gbte_dp.sv]
// gbte_dp: gap-buffer datapath with the byte store, gap pointers, dirty flag
// and result registers. Uses gbte_pkg; sequenced by gbte_ctrl.
`default_nettype none

module gbte_dp
    import gbte_pkg::*;
#(
    parameter int CAPACITY = GBTE_CAPACITY
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [GBTE_KIND_W-1:0] kind,
    input  wire logic [GBTE_CHAR_W-1:0] char_in,
    input  wire logic [GBTE_POS_W-1:0]  position,
    input  wire dp_cmd_t                cmd,
    output dp_stat_t                    stat,
    output logic [GBTE_CHAR_W-1:0]      read_char,
    output logic [GBTE_POS_W-1:0]       doc_length,
    output logic [GBTE_POS_W-1:0]       cursor_pos,
    output logic                        modified,
    output logic                        accepted
);

    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CMP_W  = (PTR_W > GBTE_POS_W) ? PTR_W : GBTE_POS_W;
    localparam logic [PTR_W-1:0] CAP_P = PTR_W'(CAPACITY);

    logic [GBTE_CHAR_W-1:0] mem [CAPACITY];

    cmd_kind_t              kind_reg;
    logic [GBTE_CHAR_W-1:0] char_reg;
    logic [GBTE_POS_W-1:0]  pos_reg;
    logic [PTR_W-1:0]       gs_reg;
    logic [PTR_W-1:0]       gs_next;
    logic [PTR_W-1:0]       ge_reg;
    logic [PTR_W-1:0]       ge_next;
    logic                   dirty_reg;
    logic                   dirty_next;
    logic                   left_reg;
    logic                   left_next;
    logic                   acc_reg;
    logic                   hit_reg;
    logic [GBTE_CHAR_W-1:0] rdata_reg;

    logic [GBTE_CHAR_W-1:0] res_char_reg;
    logic [GBTE_POS_W-1:0]  res_len_reg;
    logic [GBTE_POS_W-1:0]  res_cur_reg;
    logic                   res_mod_reg;
    logic                   res_acc_reg;

    logic [PTR_W-1:0]       gap;
    logic [PTR_W-1:0]       len;
    logic [PTR_W-1:0]       gs_dec;
    logic [PTR_W-1:0]       ge_dec;
    logic [CMP_W-1:0]       pos_c;
    logic [CMP_W-1:0]       len_c;
    logic [CMP_W-1:0]       gs_c;
    logic [CMP_W-1:0]       target;
    logic [CMP_W-1:0]       idx_c;

    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [GBTE_CHAR_W-1:0] wr_data;

    assign gap    = ge_reg - gs_reg;
    assign len    = CAP_P - gap;
    assign gs_dec = gs_reg - PTR_W'(1);
    assign ge_dec = ge_reg - PTR_W'(1);
    assign pos_c  = CMP_W'(pos_reg);
    assign len_c  = CMP_W'(len);
    assign gs_c   = CMP_W'(gs_reg);
    assign target = (pos_c > len_c) ? len_c : pos_c;
    assign idx_c  = (pos_c < gs_c) ? pos_c : pos_c + CMP_W'(gap);

    assign stat.kind       = kind_reg;
    assign stat.full       = (gs_reg == ge_reg);
    assign stat.at_start   = (gs_reg == '0);
    assign stat.at_end     = (ge_reg == CAP_P);
    assign stat.need_left  = (gs_c > target);
    assign stat.need_right = (gs_c < target);
    assign stat.in_range   = (pos_c < len_c);

    always_comb
    begin
        gs_next    = gs_reg;
        ge_next    = ge_reg;
        dirty_next = dirty_reg;
        left_next  = left_reg;
        rd_en      = 1'b0;
        rd_addr    = ADDR_W'(ge_reg);
        wr_en      = 1'b0;
        wr_addr    = ADDR_W'(gs_reg);
        wr_data    = char_reg;
        unique case (cmd.op)
            OP_INSERT:
            begin
                wr_en      = 1'b1;
                gs_next    = gs_reg + PTR_W'(1);
                dirty_next = 1'b1;
            end
            OP_BACKSPACE:
            begin
                gs_next    = gs_dec;
                dirty_next = 1'b1;
            end
            OP_FETCH_LEFT:
            begin
                rd_en     = 1'b1;
                rd_addr   = ADDR_W'(gs_dec);
                left_next = 1'b1;
            end
            OP_FETCH_RIGHT:
            begin
                rd_en     = 1'b1;
                rd_addr   = ADDR_W'(ge_reg);
                left_next = 1'b0;
            end
            OP_STORE:
            begin
                wr_en   = 1'b1;
                wr_data = rdata_reg;
                if (left_reg)
                begin
                    wr_addr = ADDR_W'(ge_dec);
                    gs_next = gs_dec;
                    ge_next = ge_dec;
                end
                else
                begin
                    gs_next = gs_reg + PTR_W'(1);
                    ge_next = ge_reg + PTR_W'(1);
                end
            end
            OP_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(idx_c);
            end
            OP_CLEAR:
            begin
                gs_next    = '0;
                ge_next    = CAP_P;
                dirty_next = 1'b0;
            end
            OP_CLEAN:
            begin
                dirty_next = 1'b0;
            end
            default:
            begin
                gs_next = gs_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg    <= '0;
            ge_reg    <= CAP_P;
            dirty_reg <= 1'b0;
        end
        else
        begin
            gs_reg    <= gs_next;
            ge_reg    <= ge_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        if (cmd.latch)
        begin
            kind_reg <= cmd_kind_t'(kind);
            char_reg <= char_in;
            pos_reg  <= position;
        end
        if (cmd.acc_we)
        begin
            acc_reg <= cmd.acc;
            hit_reg <= (cmd.op == OP_READ);
        end
        if (cmd.result)
        begin
            res_char_reg <= hit_reg ? rdata_reg : '0;
            res_len_reg  <= GBTE_POS_W'(len);
            res_cur_reg  <= GBTE_POS_W'(gs_reg);
            res_mod_reg  <= dirty_reg;
            res_acc_reg  <= acc_reg;
        end
    end

    assign read_char  = res_char_reg;
    assign doc_length = res_len_reg;
    assign cursor_pos = res_cur_reg;
    assign modified   = res_mod_reg;
    assign accepted   = res_acc_reg;

    a_gap_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        gs_reg <= ge_reg)
        else $error("gap start passed gap end");

    a_gap_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        ge_reg <= CAP_P)
        else $error("gap end beyond store capacity");

    a_copy_keeps_gap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_STORE |=> (ge_reg - gs_reg) == $past(ge_reg - gs_reg))
        else $error("byte copy changed the gap size");

endmodule

`default_nettype wire

[hw/rtl/gap_buffer_text_editor_unit.sv]
// gap_buffer_text_editor_unit: gap-buffer text store top level; uses gbte_pkg, gbte_ctrl, gbte_dp.
// Insert, backspace, read_at, clear, mark_clean: an execute state, then the done state loads the result.
// Left, right: when the cursor can move, one store read (execute) then one store write (copy).
// Move_to: per byte walked across the gap, one store read (execute) then one store write (copy).
// Result sits in an output register; the next word is taken in the cycle the result loads.
// Reset: async active-low; empty document, cursor 0, clean; store contents are not cleared.
`default_nettype none

module gap_buffer_text_editor_unit
    import gbte_pkg::*;
#(
    parameter int CAPACITY = GBTE_CAPACITY
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [GBTE_KIND_W-1:0] kind,
    input  wire logic [GBTE_CHAR_W-1:0] char_in,
    input  wire logic [GBTE_POS_W-1:0]  position,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [GBTE_CHAR_W-1:0]      read_char,
    output logic [GBTE_POS_W-1:0]       doc_length,
    output logic [GBTE_POS_W-1:0]       cursor_pos,
    output logic                        modified,
    output logic                        accepted
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    gbte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    gbte_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (kind),
        .char_in    (char_in),
        .position   (position),
        .cmd        (cmd),
        .stat       (stat),
        .read_char  (read_char),
        .doc_length (doc_length),
        .cursor_pos (cursor_pos),
        .modified   (modified),
        .accepted   (accepted)
    );

endmodule

`default_nettype wire

[tb/sv/gap_buffer_text_editor_unit_tb.sv]
`timescale 1ns / 100ps
// gap_buffer_text_editor_unit_tb: self-checking bench for the gap-buffer text editor unit.
// Sends edit commands, predicts every status word in step and compares each field.
// Depends on gbte_pkg and gap_buffer_text_editor_unit.

module gap_buffer_text_editor_unit_tb;
    import gbte_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [GBTE_CHAR_W-1:0] rd;
        logic [GBTE_POS_W-1:0]  len;
        logic [GBTE_POS_W-1:0]  cur;
        logic                   mod;
        logic                   acc;
    } edit_status_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [GBTE_KIND_W-1:0] kind;
    logic [GBTE_CHAR_W-1:0] char_in;
    logic [GBTE_POS_W-1:0]  position;
    logic                   out_valid;
    logic                   out_stall;
    logic [GBTE_CHAR_W-1:0] read_char;
    logic [GBTE_POS_W-1:0]  doc_length;
    logic [GBTE_POS_W-1:0]  cursor_pos;
    logic                   modified;
    logic                   accepted;

    logic [GBTE_CHAR_W-1:0] doc_store [GBTE_CAPACITY];
    int unsigned            gap_lo = 0;
    int unsigned            gap_hi = GBTE_CAPACITY;
    logic                   text_changed = 1'b0;
    edit_status_t           status_q [$];
    edit_status_t           status_want;
    int                     mismatches = 0;
    int unsigned            cycles = 0;
    bit                     idle_en = 1'b1;
    bit                     hold_req = 1'b0;

    gap_buffer_text_editor_unit uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .char_in    (char_in),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_char  (read_char),
        .doc_length (doc_length),
        .cursor_pos (cursor_pos),
        .modified   (modified),
        .accepted   (accepted)
    );

    always #5 clk = ~clk;

    function automatic int unsigned doc_len();
        return GBTE_CAPACITY - (gap_hi - gap_lo);
    endfunction

    function automatic void shift_left();
        gap_lo--;
        gap_hi--;
        doc_store[gap_hi] = doc_store[gap_lo];
    endfunction

    function automatic void shift_right();
        doc_store[gap_lo] = doc_store[gap_hi];
        gap_lo++;
        gap_hi++;
    endfunction

    function automatic edit_status_t predict_edit(cmd_kind_t k, logic [GBTE_CHAR_W-1:0] c,
                                                  logic [GBTE_POS_W-1:0] p);
        edit_status_t s;
        int unsigned  target;
        s = '0;
        target = 32'(p);
        case (k)
            KIND_INSERT:
                if (gap_lo < gap_hi)
                begin
                    doc_store[gap_lo] = c;
                    gap_lo++;
                    text_changed = 1'b1;
                    s.acc = 1'b1;
                end
            KIND_BACKSPACE:
                if (gap_lo > 0)
                begin
                    gap_lo--;
                    text_changed = 1'b1;
                    s.acc = 1'b1;
                end
            KIND_LEFT:
                if (gap_lo > 0)
                begin
                    shift_left();
                    s.acc = 1'b1;
                end
            KIND_RIGHT:
                if (gap_hi < GBTE_CAPACITY)
                begin
                    shift_right();
                    s.acc = 1'b1;
                end
            KIND_MOVE_TO:
            begin
                if (target > doc_len())
                    target = doc_len();
                while (gap_lo > target)
                    shift_left();
                while (gap_lo < target)
                    shift_right();
                s.acc = 1'b1;
            end
            KIND_READ_AT:
                if (target < doc_len())
                begin
                    s.rd = doc_store[target < gap_lo ? target : target + gap_hi - gap_lo];
                    s.acc = 1'b1;
                end
            KIND_CLEAR:
            begin
                gap_lo = 0;
                gap_hi = GBTE_CAPACITY;
                text_changed = 1'b0;
                s.acc = 1'b1;
            end
            default:
            begin
                text_changed = 1'b0;
                s.acc = 1'b1;
            end
        endcase
        s.len = GBTE_POS_W'(doc_len());
        s.cur = GBTE_POS_W'(gap_lo);
        s.mod = text_changed;
        return s;
    endfunction

    function automatic void check_field(string name, logic [GBTE_POS_W-1:0] want_v,
                                        logic [GBTE_POS_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic logic [GBTE_POS_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0: return GBTE_POS_W'($urandom);
            1: return GBTE_POS_W'($urandom_range(0, GBTE_CAPACITY));
            default: return GBTE_POS_W'($urandom_range(0, doc_len() + 2));
        endcase
    endfunction

    task automatic send_word(input cmd_kind_t k, input logic [GBTE_CHAR_W-1:0] c,
                             input logic [GBTE_POS_W-1:0] p);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        char_in  <= c;
        position <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        status_q.push_back(predict_edit(k, c, p));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_edit();
        int        roll;
        cmd_kind_t k;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            k = KIND_INSERT;
        else if (roll < 47)
            k = KIND_BACKSPACE;
        else if (roll < 57)
            k = KIND_LEFT;
        else if (roll < 67)
            k = KIND_RIGHT;
        else if (roll < 77)
            k = KIND_MOVE_TO;
        else if (roll < 92)
            k = KIND_READ_AT;
        else if (roll < 97)
            k = KIND_MARK_CLEAN;
        else
            k = KIND_CLEAR;
        send_word(k, GBTE_CHAR_W'($urandom), pick_position());
    endtask

    task automatic test_empty_document();
        send_word(KIND_BACKSPACE, 8'h00, 13'd0);
        send_word(KIND_LEFT, 8'h00, 13'd0);
        send_word(KIND_RIGHT, 8'h00, 13'd0);
        send_word(KIND_READ_AT, 8'h00, 13'd0);
        send_word(KIND_READ_AT, 8'hFF, 13'h1FFF);
        send_word(KIND_MOVE_TO, 8'h00, 13'd4096);
        send_word(KIND_MARK_CLEAN, 8'h00, 13'd0);
    endtask

    task automatic test_basic_edits();
        send_word(KIND_INSERT, 8'h00, 13'd0);
        send_word(KIND_INSERT, 8'hFF, 13'h1FFF);
        send_word(KIND_INSERT, 8'hA5, 13'd0);
        send_word(KIND_INSERT, 8'h5A, 13'd0);
        send_word(KIND_READ_AT, 8'h00, 13'd0);
        send_word(KIND_LEFT, 8'h00, 13'd0);
        send_word(KIND_LEFT, 8'h00, 13'd0);
        send_word(KIND_READ_AT, 8'h00, 13'd3);
        send_word(KIND_MARK_CLEAN, 8'h00, 13'd0);
        send_word(KIND_RIGHT, 8'h00, 13'd0);
        send_word(KIND_READ_AT, 8'h00, 13'd4);
        send_word(KIND_BACKSPACE, 8'h00, 13'd0);
        send_word(KIND_INSERT, 8'h3C, 13'd0);
        send_word(KIND_MOVE_TO, 8'h00, 13'd0);
        send_word(KIND_BACKSPACE, 8'h00, 13'd0);
        send_word(KIND_MOVE_TO, 8'h00, 13'h1FFF);
        send_word(KIND_RIGHT, 8'h00, 13'd0);
        send_word(KIND_READ_AT, 8'h00, 13'h1000);
        send_word(KIND_CLEAR, 8'h00, 13'd0);
        send_word(KIND_READ_AT, 8'h00, 13'd0);
    endtask

    task automatic test_stall_pressure();
        drain_results();
        @(posedge clk);
        hold_req = 1'b1;
        send_word(KIND_INSERT, 8'h41, 13'd0);
        repeat (23)
            send_random_edit();
        drain_results();
    endtask

    task automatic test_random_sessions(input int words);
        int sent;
        int load_len;
        int edits;
        sent = 0;
        while (sent < words)
        begin
            send_word(KIND_CLEAR, GBTE_CHAR_W'($urandom), GBTE_POS_W'($urandom));
            load_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                   : $urandom_range(0, 40);
            repeat (load_len)
                send_word(KIND_INSERT, GBTE_CHAR_W'($urandom), GBTE_POS_W'($urandom));
            if ($urandom_range(0, 4) != 0)
                send_word(KIND_MARK_CLEAN, GBTE_CHAR_W'($urandom), GBTE_POS_W'($urandom));
            edits = $urandom_range(10, 40);
            repeat (edits)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_word(cmd_kind_t'($urandom_range(0, 7)), GBTE_CHAR_W'($urandom),
                              GBTE_POS_W'($urandom));
                else
                    send_random_edit();
            end
            sent += 2 + load_len + edits;
        end
    endtask

    task automatic test_quiet_tail(input int words);
        drain_results();
        idle_en = 1'b0;
        repeat (words)
            send_random_edit();
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual len %0d cur %0d",
                         $time, doc_length, cursor_pos);
                mismatches++;
            end
            else
            begin
                status_want = status_q.pop_front();
                check_field("read_char", GBTE_POS_W'(status_want.rd), GBTE_POS_W'(read_char));
                check_field("doc_length", status_want.len, doc_length);
                check_field("cursor_pos", status_want.cur, cursor_pos);
                check_field("modified", GBTE_POS_W'(status_want.mod), GBTE_POS_W'(modified));
                check_field("accepted", GBTE_POS_W'(status_want.acc), GBTE_POS_W'(accepted));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        kind     = KIND_INSERT;
        char_in  = '0;
        position = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_document();
        test_basic_edits();
        test_stall_pressure();
        test_random_sessions(520);
        test_quiet_tail(150);

        drain_results();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
